[rtl/fra_pkg.sv]
package fra_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int COUNT_BITS = 16;

    localparam int CH_BITS  = 8;
    localparam int NUM_CH   = 3;
    localparam int CFG_BITS = 9;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_HEIGHT = 1'b1;

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int COL_BITS    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_BITS    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    localparam int DIM_W_BITS = $clog2(MAX_WIDTH + 1) + 1;
    localparam int DIM_H_BITS = $clog2(MAX_HEIGHT + 1) + 1;
    localparam int DIM_WH     = (DIM_W_BITS > DIM_H_BITS) ? DIM_W_BITS : DIM_H_BITS;
    localparam int DIM_BITS   = (DIM_WH > CFG_BITS) ? DIM_WH : CFG_BITS;

    localparam int NUM_BITS   = CH_BITS + COUNT_BITS;
    localparam int DIV_STAGES = CH_BITS;

    localparam logic [CFG_BITS-1:0] CFG_RESET_WIDTH  = CFG_BITS'(256);
    localparam logic [CFG_BITS-1:0] CFG_RESET_HEIGHT = CFG_BITS'(256);

    typedef logic [NUM_CH-1:0][CH_BITS-1:0] t_rgb;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  addr;
        logic [COUNT_BITS-1:0] n;
        logic                  frame_end;
    } t_pos;

    typedef struct packed {
        logic [NUM_CH-1:0][NUM_BITS-1:0] rem;
        t_rgb                            quo;
        logic [COUNT_BITS:0]             dvs;
        logic [ADDR_BITS-1:0]            addr;
        logic                            frame_end;
    } t_div_word;

    typedef struct packed {
        logic                 en;
        logic [ADDR_BITS-1:0] addr;
        t_rgb                 data;
    } t_wr;

endpackage

[rtl/fra_pix_if.sv]
interface fra_pix_if;
    logic                        valid;
    logic                        ready;
    logic [fra_pkg::CH_BITS-1:0] in_blue;
    logic [fra_pkg::CH_BITS-1:0] in_green;
    logic [fra_pkg::CH_BITS-1:0] in_red;

    modport source (output valid, output in_blue, output in_green, output in_red,
                    input ready);
    modport sink (input valid, input in_blue, input in_green, input in_red,
                  output ready);
endinterface

[rtl/fra_avg_if.sv]
interface fra_avg_if;
    logic                        valid;
    logic                        ready;
    logic [fra_pkg::CH_BITS-1:0] avg_blue;
    logic [fra_pkg::CH_BITS-1:0] avg_green;
    logic [fra_pkg::CH_BITS-1:0] avg_red;
    logic                        frame_end;

    modport source (output valid, output avg_blue, output avg_green, output avg_red,
                    output frame_end, input ready);
    modport sink (input valid, input avg_blue, input avg_green, input avg_red,
                  input frame_end, output ready);
endinterface

[rtl/fra_ram.sv]
module fra_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/fra_raster.sv]
module fra_raster (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [fra_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [fra_pkg::CFG_BITS-1:0]         i_cfg_data,
    input  logic                                 i_adv,
    output fra_pkg::t_pos                        o_pos
);

    localparam logic [fra_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [fra_pkg::CFG_BITS-1:0]   r_width;
    logic [fra_pkg::CFG_BITS-1:0]   r_height;
    logic [fra_pkg::COL_BITS-1:0]   r_col;
    logic [fra_pkg::ROW_BITS-1:0]   r_row;
    logic [fra_pkg::COUNT_BITS-1:0] r_frames;

    logic [fra_pkg::DIM_BITS-1:0] eff_w;
    logic [fra_pkg::DIM_BITS-1:0] eff_h;
    logic [fra_pkg::DIM_BITS-1:0] col_inc;
    logic [fra_pkg::DIM_BITS-1:0] row_inc;
    logic                         line_end;
    logic                         frame_last;

    always_comb begin
        if (r_width == '0) begin
            eff_w = fra_pkg::DIM_BITS'(1);
        end else if (fra_pkg::DIM_BITS'(r_width) > fra_pkg::DIM_BITS'(fra_pkg::MAX_WIDTH)) begin
            eff_w = fra_pkg::DIM_BITS'(fra_pkg::MAX_WIDTH);
        end else begin
            eff_w = fra_pkg::DIM_BITS'(r_width);
        end
        if (r_height == '0) begin
            eff_h = fra_pkg::DIM_BITS'(1);
        end else if (fra_pkg::DIM_BITS'(r_height) > fra_pkg::DIM_BITS'(fra_pkg::MAX_HEIGHT)) begin
            eff_h = fra_pkg::DIM_BITS'(fra_pkg::MAX_HEIGHT);
        end else begin
            eff_h = fra_pkg::DIM_BITS'(r_height);
        end
        col_inc    = fra_pkg::DIM_BITS'(r_col) + fra_pkg::DIM_BITS'(1);
        row_inc    = fra_pkg::DIM_BITS'(r_row) + fra_pkg::DIM_BITS'(1);
        line_end   = col_inc >= eff_w;
        frame_last = line_end && (row_inc >= eff_h);
    end

    always_comb begin
        o_pos.addr      = fra_pkg::ADDR_BITS'(int'(r_row) * fra_pkg::MAX_WIDTH + int'(r_col));
        o_pos.n         = r_frames;
        o_pos.frame_end = frame_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= fra_pkg::CFG_RESET_WIDTH;
            r_height <= fra_pkg::CFG_RESET_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                fra_pkg::CFG_IDX_WIDTH:  r_width  <= i_cfg_data;
                fra_pkg::CFG_IDX_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_frames <= '0;
        end else if (i_adv) begin
            if (line_end) begin
                r_col <= '0;
                if (frame_last) begin
                    r_row <= '0;
                    if (r_frames != COUNT_MAX) begin
                        r_frames <= r_frames + 1'b1;
                    end
                end else begin
                    r_row <= fra_pkg::ROW_BITS'(row_inc);
                end
            end else begin
                r_col <= fra_pkg::COL_BITS'(col_inc);
            end
        end
    end

    a_frame_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && frame_last && (r_frames != COUNT_MAX) |=> r_frames == $past(r_frames) + 1'b1)
        else $error("frame count did not advance at frame end");

    a_hold_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_adv |=> $stable(r_col) && $stable(r_row) && $stable(r_frames))
        else $error("raster position moved without a transfer");

endmodule

[rtl/fra_divider.sv]
module fra_divider (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  fra_pkg::t_div_word             i_word,
    output logic                           o_valid,
    input  logic                           i_ready,
    output fra_pkg::t_div_word             o_word,
    input  logic [fra_pkg::ADDR_BITS-1:0]  i_probe_addr,
    output logic                           o_hit,
    output fra_pkg::t_wr                   o_wr
);

    localparam int NS = fra_pkg::DIV_STAGES;

    fra_pkg::t_div_word r_st [NS];
    logic [NS-1:0]      r_v;
    fra_pkg::t_div_word nxt  [NS];
    logic [NS-1:0]      src_v;
    logic [NS-1:0]      stg_ready;

    always_comb begin
        fra_pkg::t_div_word src;
        logic [fra_pkg::NUM_BITS:0] cmp;
        logic [fra_pkg::NUM_BITS:0] rem_x;
        int sh;
        for (int k = 0; k < NS; k++) begin
            src = (k == 0) ? i_word : r_st[(k == 0) ? 0 : k - 1];
            src_v[k] = (k == 0) ? i_valid : r_v[(k == 0) ? 0 : k - 1];
            sh = NS - 1 - k;
            nxt[k] = src;
            cmp = (fra_pkg::NUM_BITS + 1)'(src.dvs) << sh;
            for (int c = 0; c < fra_pkg::NUM_CH; c++) begin
                rem_x = {1'b0, src.rem[c]};
                if (rem_x >= cmp) begin
                    nxt[k].rem[c]     = fra_pkg::NUM_BITS'(rem_x - cmp);
                    nxt[k].quo[c][sh] = 1'b1;
                end
            end
        end
    end

    always_comb begin
        stg_ready[NS-1] = !r_v[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            stg_ready[k] = !r_v[k] || stg_ready[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (stg_ready[k]) begin
                    r_v[k] <= src_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NS; k++) begin
            if (stg_ready[k] && src_v[k]) begin
                r_st[k] <= nxt[k];
            end
        end
    end

    // the last stage is already written back, the rest are in flight
    always_comb begin
        o_hit = 1'b0;
        for (int k = 0; k < NS - 1; k++) begin
            if (r_v[k] && (r_st[k].addr == i_probe_addr)) begin
                o_hit = 1'b1;
            end
        end
    end

    assign o_wr.en   = src_v[NS-1] && stg_ready[NS-1];
    assign o_wr.addr = nxt[NS-1].addr;
    assign o_wr.data = nxt[NS-1].quo;

    assign o_ready = stg_ready[0];
    assign o_valid = r_v[NS-1];
    assign o_word  = r_st[NS-1];

endmodule

[rtl/frame_running_average.sv]
// frame_running_average
// Per-pixel cumulative average over video frames. Pixels enter in raster order
// on i_pix (valid/ready, one transfer per pixel); every pixel produces one
// averaged pixel on o_avg, with frame_end set on the last pixel of a frame.
// Frame width and height are written on the config port (index 0 width,
// index 1 height) while the block is idle; 0 acts as 1 and values above the
// maximum are clamped.
// Path of a pixel: the store read and the pixel register load at the input
// transfer, then the weight multiply is registered, then the radix-2 divider
// gives one quotient bit per stage for all three channels.
// Throughput: one pixel per cycle while o_avg is ready. A pixel whose store
// entry is still in the pipeline waits until that entry is written back, so
// frames of fewer than ten positions run slower.
// Reset clears position and frame count and sets the sizes to 256 x 256; the
// store is not cleared, since the first frame passes through unchanged.
// When the receiver stalls, results hold in the pipeline; input transfers go
// on until every stage is full, then i_pix.ready drops.
module frame_running_average (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fra_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [fra_pkg::CFG_BITS-1:0]     i_cfg_data,
    fra_pix_if.sink                          i_pix,
    fra_avg_if.source                        o_avg
);

    typedef struct packed {
        logic [fra_pkg::ADDR_BITS-1:0]  addr;
        logic [fra_pkg::COUNT_BITS-1:0] n;
        fra_pkg::t_rgb                  pix;
        logic                           frame_end;
    } t_s1;

    fra_pkg::t_pos      pos;
    fra_pkg::t_rgb      rd_data;
    fra_pkg::t_wr       wr;
    fra_pkg::t_div_word n_s2;
    fra_pkg::t_div_word r_s2;
    fra_pkg::t_div_word div_out;
    t_s1                r_s1;
    logic               r_s1_valid;
    logic               r_s2_valid;
    logic               div_ready;
    logic               div_hit;
    logic               s1_ready;
    logic               s2_ready;
    logic               hazard;
    logic               in_xfer;

    assign s2_ready = !r_s2_valid || div_ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign hazard   = div_hit
                   || (r_s1_valid && (r_s1.addr == pos.addr))
                   || (r_s2_valid && (r_s2.addr == pos.addr));
    assign i_pix.ready = s1_ready && !hazard;
    assign in_xfer     = i_pix.valid && i_pix.ready;

    fra_raster u_raster (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_adv      (in_xfer),
        .o_pos      (pos)
    );

    fra_ram #(
        .WIDTH ($bits(fra_pkg::t_rgb)),
        .DEPTH (fra_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr.en),
        .i_waddr (wr.addr),
        .i_wdata (wr.data),
        .i_re    (in_xfer),
        .i_raddr (pos.addr),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= in_xfer;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1.addr      <= pos.addr;
            r_s1.n         <= pos.n;
            r_s1.pix       <= {i_pix.in_red, i_pix.in_green, i_pix.in_blue};
            r_s1.frame_end <= pos.frame_end;
        end
        if (s2_ready && r_s1_valid) begin
            r_s2 <= n_s2;
        end
    end

    // weighted sum; first frame ignores the store, which may be unwritten
    always_comb begin
        n_s2.quo       = '0;
        n_s2.dvs       = (fra_pkg::COUNT_BITS + 1)'(r_s1.n) + 1'b1;
        n_s2.addr      = r_s1.addr;
        n_s2.frame_end = r_s1.frame_end;
        for (int c = 0; c < fra_pkg::NUM_CH; c++) begin
            if (r_s1.n == '0) begin
                n_s2.rem[c] = fra_pkg::NUM_BITS'(r_s1.pix[c]);
            end else begin
                n_s2.rem[c] = fra_pkg::NUM_BITS'(rd_data[c]) * fra_pkg::NUM_BITS'(r_s1.n)
                            + fra_pkg::NUM_BITS'(r_s1.pix[c]);
            end
        end
    end

    fra_divider u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_s2_valid),
        .o_ready      (div_ready),
        .i_word       (r_s2),
        .o_valid      (o_avg.valid),
        .i_ready      (o_avg.ready),
        .o_word       (div_out),
        .i_probe_addr (pos.addr),
        .o_hit        (div_hit),
        .o_wr         (wr)
    );

    assign o_avg.avg_blue  = div_out.quo[0];
    assign o_avg.avg_green = div_out.quo[1];
    assign o_avg.avg_red   = div_out.quo[2];
    assign o_avg.frame_end = div_out.frame_end;

    a_no_stale_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr.en |-> !(r_s1_valid && (r_s1.addr == wr.addr)))
        else $error("write back to an entry with a read already in flight");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s2_ready |=> r_s1_valid && $stable(r_s1.addr) && $stable(r_s1.n))
        else $error("read stage lost its item during a stall");

endmodule
